// ===== rtl/gda_pkg.sv =====
// Shared types, constants and a lookup function for the gamepad direction autorepeat block.
package gda_pkg;

  localparam int unsigned ButtonCount  = 30;
  localparam int unsigned StickCount   = 2;
  localparam int unsigned TriggerCount = 2;
  localparam int unsigned TaskCount    = ButtonCount + StickCount + TriggerCount + 1;
  localparam int unsigned TaskIdxW     = $clog2(TaskCount);

  localparam logic [TaskIdxW-1:0] StickBase = TaskIdxW'(ButtonCount);
  localparam logic [TaskIdxW-1:0] TrigBase  = TaskIdxW'(ButtonCount + StickCount);
  localparam logic [TaskIdxW-1:0] HatTask   = TaskIdxW'(ButtonCount + StickCount + TriggerCount);
  localparam logic [TaskIdxW-1:0] LastTask  = TaskIdxW'(TaskCount - 1);

  // operation codes
  localparam logic [1:0] OpAxis   = 2'd0;
  localparam logic [1:0] OpHat    = 2'd1;
  localparam logic [1:0] OpButton = 2'd2;
  localparam logic [1:0] OpTick   = 2'd3;

  // key kinds
  localparam logic [2:0] KindPad   = 3'd0;
  localparam logic [2:0] KindEsc   = 3'd1;
  localparam logic [2:0] KindEnter = 3'd2;
  localparam logic [2:0] KindUp    = 3'd3;
  localparam logic [2:0] KindDown  = 3'd4;
  localparam logic [2:0] KindLeft  = 3'd5;
  localparam logic [2:0] KindRight = 3'd6;

  // buttons mapped to keyboard keys
  localparam logic [4:0] BtnEsc   = 5'd4;
  localparam logic [4:0] BtnEnter = 5'd6;
  localparam logic [4:0] BtnUp    = 5'd11;
  localparam logic [4:0] BtnDown  = 5'd12;
  localparam logic [4:0] BtnLeft  = 5'd13;
  localparam logic [4:0] BtnRight = 5'd14;

  // code bases
  localparam logic [5:0] Stick0Base = 6'd31;
  localparam logic [5:0] Stick1Base = 6'd21;
  localparam logic [5:0] HatBase    = 6'd31;
  localparam logic [5:0] TrigCode   = 6'd29;

  // config register indexes
  localparam logic [2:0] RegTrigThr  = 3'd0;
  localparam logic [2:0] RegStickThr = 3'd1;
  localparam logic [2:0] RegMargin   = 3'd2;
  localparam logic [2:0] RegDelay    = 3'd3;
  localparam logic [2:0] RegPeriod   = 3'd4;
  localparam logic [2:0] RegDiag     = 3'd5;

  typedef struct packed {
    logic load;      // latch input word
    logic ev_rd;     // read task entry of the event
    logic ev_exec;   // apply event, push its result
    logic sc_start;  // clear scan index and pending code
    logic sc_rd;     // read task entry at scan index
    logic sc_chk;    // evaluate entry, advance index
    logic sc_flush;  // push pending code as last
  } cmd_t;

  typedef struct packed {
    logic is_tick;
    logic out_free;
    logic idx_last;
    logic pend_valid;
    logic due_hit;
  } stat_t;

  // direction pattern -> {none, slot}; slots up,right,down,left,ru,rd,ld,lu
  function automatic logic [3:0] dir_slot(input logic [3:0] d);
    logic [3:0] r;
    case (d)
      4'd1:    r = 4'b0000;
      4'd2:    r = 4'b0001;
      4'd3:    r = 4'b0100;
      4'd4:    r = 4'b0010;
      4'd6:    r = 4'b0101;
      4'd8:    r = 4'b0011;
      4'd9:    r = 4'b0111;
      4'd12:   r = 4'b0110;
      default: r = 4'b1000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/gamepad_direction_autorepeat.sv =====
// Top level of the gamepad direction and autorepeat block.
// Takes one gamepad event word at a time (axis, hat, button or scheduler
// tick) and produces key words on the master stream, tlast marking the last
// word caused by one event. The block handles one event at a time: tready is
// high only while idle. An axis, hat or button event steps through accept,
// decode with task table read and execute; the execute step waits for a
// free output register and then loads the key word into it. A tick walks the
// 35 repeat tasks through the single-port task table, a read and a check step
// per task, and a check waits while a due code is pending and the output is
// full; due codes go out one behind the scan so the final one can carry
// tlast. The output register lets the next event be accepted while a key
// word still waits. Config writes are always ready and are meant to land
// only while the block is idle.
module gamepad_direction_autorepeat (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: axis_index[2:0], axis_value[18:3], hat_value[22:19],
  //        button_index[27:23], button_pressed[28], timestamp[60:29], zero pad
  input  logic [63:0] s_axis_tdata_i,
  // tuser: operation[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tdata: key_code[5:0], zero pad
  output logic [7:0]  m_axis_tdata_o,
  // tuser: key_kind[2:0]
  output logic [2:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_data_i
);

  gda_pkg::cmd_t  cmd;
  gda_pkg::stat_t stat;
  logic [5:0]     key_code;

  assign cfg_ready_o = 1'b1;

  gda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gda_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_op_i     (s_axis_tuser_i),
    .in_data_i   (s_axis_tdata_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_kind_o  (m_axis_tuser_o),
    .out_code_o  (key_code),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, key_code};

endmodule

// ===== rtl/gda_ctrl.sv =====
// Sequencer for event handling and the repeat task scan.
module gda_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gda_pkg::stat_t stat_i,
  output gda_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StDec   = 3'd1;
  localparam logic [2:0] StEvEx  = 3'd2;
  localparam logic [2:0] StScRd  = 3'd3;
  localparam logic [2:0] StScChk = 3'd4;
  localparam logic [2:0] StScFl  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDec;
        end
      end
      StDec: begin
        if (stat_i.is_tick) begin
          cmd_o.sc_start = 1'b1;
          state_d        = StScRd;
        end else begin
          cmd_o.ev_rd = 1'b1;
          state_d     = StEvEx;
        end
      end
      StEvEx: begin
        if (stat_i.out_free) begin
          cmd_o.ev_exec = 1'b1;
          state_d       = StIdle;
        end
      end
      StScRd: begin
        cmd_o.sc_rd = 1'b1;
        state_d     = StScChk;
      end
      StScChk: begin
        // a hit with a code already pending needs the output slot
        if (!(stat_i.due_hit && stat_i.pend_valid && !stat_i.out_free)) begin
          cmd_o.sc_chk = 1'b1;
          state_d      = stat_i.idx_last ? StScFl : StScRd;
        end
      end
      StScFl: begin
        if (!stat_i.pend_valid) begin
          state_d = StIdle;
        end else if (stat_i.out_free) begin
          cmd_o.sc_flush = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/gda_dp.sv =====
// Datapath: config, direction state, task table, scan and output register.
module gda_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gda_pkg::cmd_t  cmd_i,
  output gda_pkg::stat_t stat_o,
  input  logic [1:0]     in_op_i,
  input  logic [63:0]    in_data_i,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_addr_i,
  input  logic [15:0]    cfg_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [2:0]     out_kind_o,
  output logic [5:0]     out_code_o,
  output logic           out_last_o
);

  localparam int unsigned IW = gda_pkg::TaskIdxW;

  // config
  logic [14:0] trig_thr_q, stick_thr_q;
  logic [13:0] margin_q;
  logic [15:0] delay_q, period_q, diag_q;

  // latched input word
  logic [1:0]  op_q;
  logic [2:0]  axis_q;
  logic [15:0] val_q;
  logic [3:0]  hat_in_q;
  logic [4:0]  btn_q;
  logic        pr_q;
  logic [31:0] now_q;

  // direction state
  logic [1:0]       trig_on_q, trig_d;
  logic [1:0][3:0]  stick_q, stick_d;
  logic [3:0]       hat_q, hat_d;
  logic [1:0]       cnt_q [gda_pkg::TaskCount];

  // task table: {due, code}
  logic [37:0] mem [gda_pkg::TaskCount];
  logic [37:0] rd_q;
  logic        mem_we, rd_en;
  logic [IW-1:0] mem_wa, rd_addr;
  logic [37:0] mem_wd;

  // scan
  logic [IW-1:0] idx_q;
  logic        pend_valid_q;
  logic [5:0]  pend_code_q;

  // output register
  logic       out_valid_q;
  logic [2:0] out_kind_q;
  logic [5:0] out_code_q;
  logic       out_last_q;
  logic       push, push_last;
  logic [2:0] push_kind;
  logic [5:0] push_code;

  // event decode
  logic [IW-1:0] t_ev;
  logic [1:0]    cnt_ev;
  logic          ev_emit, ev_arm, ev_arm_diag, ev_clr;
  logic [2:0]    ev_kind;
  logic [5:0]    ev_code, ev_arm_code, dir_base;
  logic [1:0]    ev_arm_cnt;
  logic          dir_go;
  logic [3:0]    dir_old, dir_new, slot, hi_bit, lo_bit;
  logic          st_sel, tr_sel;
  logic signed [17:0] vs, th_t, th_s, mg, t_up, t_dn, s_up, s_dn, s_nup, s_ndn;
  logic          due_hit;

  assign vs   = 18'(signed'(val_q));
  assign th_t = signed'({3'b000, trig_thr_q});
  assign th_s = signed'({3'b000, stick_thr_q});
  assign mg   = signed'({4'b0000, margin_q});
  assign t_up = th_t + mg;
  assign t_dn = th_t - mg;
  assign s_up = th_s + mg;
  assign s_dn = th_s - mg;
  assign s_nup = -th_s - mg;
  assign s_ndn = mg - th_s;

  assign tr_sel = axis_q[0];
  assign st_sel = axis_q[1];
  assign hi_bit = axis_q[0] ? 4'b0100 : 4'b0010;
  assign lo_bit = axis_q[0] ? 4'b0001 : 4'b1000;

  always_comb begin
    t_ev = '0;
    case (op_q)
      gda_pkg::OpAxis: begin
        if (axis_q[2]) t_ev = gda_pkg::TrigBase + IW'(tr_sel);
        else           t_ev = gda_pkg::StickBase + IW'(st_sel);
      end
      gda_pkg::OpHat:    t_ev = gda_pkg::HatTask;
      gda_pkg::OpButton: t_ev = IW'(btn_q);
      default:           t_ev = '0;
    endcase
  end

  assign cnt_ev = cnt_q[t_ev];
  assign slot   = gda_pkg::dir_slot(dir_new);

  always_comb begin
    ev_emit     = 1'b0;
    ev_kind     = gda_pkg::KindPad;
    ev_code     = '0;
    ev_arm      = 1'b0;
    ev_arm_diag = 1'b0;
    ev_arm_code = '0;
    ev_arm_cnt  = 2'd1;
    ev_clr      = 1'b0;
    trig_d      = trig_on_q;
    stick_d     = stick_q;
    hat_d       = hat_q;
    dir_go      = 1'b0;
    dir_old     = '0;
    dir_new     = '0;
    dir_base    = gda_pkg::HatBase;
    case (op_q)
      gda_pkg::OpAxis: begin
        if (axis_q[2:1] == 2'b10) begin
          if (!trig_on_q[tr_sel] && vs > t_up) begin
            ev_emit        = 1'b1;
            ev_code        = gda_pkg::TrigCode + 6'(tr_sel);
            trig_d[tr_sel] = 1'b1;
            ev_arm         = 1'b1;
            ev_arm_code    = gda_pkg::TrigCode + 6'(tr_sel);
          end else if (trig_on_q[tr_sel] && vs < t_dn) begin
            trig_d[tr_sel] = 1'b0;
            ev_clr         = 1'b1;
          end
        end else if (!axis_q[2]) begin
          dir_go   = 1'b1;
          dir_old  = stick_q[st_sel];
          dir_new  = stick_q[st_sel];
          dir_base = st_sel ? gda_pkg::Stick1Base : gda_pkg::Stick0Base;
          if (((dir_old & hi_bit) == 4'd0) && vs > s_up)       dir_new = dir_old | hi_bit;
          else if (((dir_old & hi_bit) != 4'd0) && vs < s_dn)  dir_new = dir_old & ~hi_bit;
          else if (((dir_old & lo_bit) == 4'd0) && vs < s_nup) dir_new = dir_old | lo_bit;
          else if (((dir_old & lo_bit) != 4'd0) && vs > s_ndn) dir_new = dir_old & ~lo_bit;
          stick_d[st_sel] = dir_new;
        end
      end
      gda_pkg::OpHat: begin
        dir_go  = 1'b1;
        dir_old = hat_q;
        dir_new = hat_in_q;
        hat_d   = hat_in_q;
      end
      gda_pkg::OpButton: begin
        if (btn_q < 5'(gda_pkg::ButtonCount)) begin
          if (!pr_q) begin
            ev_clr = 1'b1;
          end else begin
            ev_emit = 1'b1;
            case (btn_q)
              gda_pkg::BtnEsc:   ev_kind = gda_pkg::KindEsc;
              gda_pkg::BtnEnter: ev_kind = gda_pkg::KindEnter;
              gda_pkg::BtnUp:    ev_kind = gda_pkg::KindUp;
              gda_pkg::BtnDown:  ev_kind = gda_pkg::KindDown;
              gda_pkg::BtnLeft:  ev_kind = gda_pkg::KindLeft;
              gda_pkg::BtnRight: ev_kind = gda_pkg::KindRight;
              default: begin
                ev_code     = 6'(btn_q);
                ev_arm      = 1'b1;
                ev_arm_code = 6'(btn_q);
              end
            endcase
          end
        end
      end
      default: ;
    endcase
    if (dir_go && dir_old != dir_new) begin
      if (dir_new == 4'd0) begin
        // quick flick: cardinal released before its first repeat
        if (cnt_ev == 2'd1 && $onehot(dir_old)) begin
          ev_emit = 1'b1;
          ev_code = rd_q[5:0];
        end
        ev_clr = 1'b1;
      end else if (!slot[3] && slot[2]) begin
        ev_emit     = 1'b1;
        ev_code     = dir_base + {3'b000, slot[2:0]};
        ev_arm      = 1'b1;
        ev_arm_code = dir_base + {3'b000, slot[2:0]};
      end else if (!slot[3]) begin
        ev_arm      = 1'b1;
        ev_arm_diag = 1'b1;
        ev_arm_code = dir_base + {3'b000, slot[2:0]};
        ev_arm_cnt  = (dir_old != 4'd0) ? 2'd2 : 2'd1;
      end
    end
  end

  assign due_hit = (cnt_q[idx_q] != 2'd0) && (rd_q[37:6] <= now_q);

  // table ports
  always_comb begin
    mem_we = 1'b0;
    mem_wa = t_ev;
    mem_wd = {now_q + {16'd0, ev_arm_diag ? diag_q : delay_q}, ev_arm_code};
    if (cmd_i.ev_exec && ev_arm) begin
      mem_we = 1'b1;
    end else if (cmd_i.sc_chk && due_hit) begin
      mem_we = 1'b1;
      mem_wa = idx_q;
      mem_wd = {now_q + {16'd0, period_q}, rd_q[5:0]};
    end
  end

  assign rd_en   = cmd_i.ev_rd | cmd_i.sc_rd;
  assign rd_addr = cmd_i.sc_rd ? idx_q : t_ev;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en)  rd_q <= mem[rd_addr];
  end

  // output push
  always_comb begin
    push      = 1'b0;
    push_kind = gda_pkg::KindPad;
    push_code = pend_code_q;
    push_last = 1'b0;
    if (cmd_i.ev_exec && ev_emit) begin
      push      = 1'b1;
      push_kind = ev_kind;
      push_code = ev_code;
      push_last = 1'b1;
    end else if (cmd_i.sc_chk && due_hit && pend_valid_q) begin
      push = 1'b1;
    end else if (cmd_i.sc_flush) begin
      push      = 1'b1;
      push_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= in_op_i;
      axis_q   <= in_data_i[2:0];
      val_q    <= in_data_i[18:3];
      hat_in_q <= in_data_i[22:19];
      btn_q    <= in_data_i[27:23];
      pr_q     <= in_data_i[28];
      now_q    <= in_data_i[60:29];
    end
    if (push) begin
      out_kind_q <= push_kind;
      out_code_q <= push_code;
      out_last_q <= push_last;
    end
    if (cmd_i.sc_chk && due_hit) pend_code_q <= rd_q[5:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_thr_q   <= 15'd16000;
      stick_thr_q  <= 15'd16000;
      margin_q     <= 14'd2000;
      delay_q      <= 16'd400;
      period_q     <= 16'd200;
      diag_q       <= 16'd250;
      trig_on_q    <= '0;
      stick_q      <= '0;
      hat_q        <= '0;
      for (int i = 0; i < int'(gda_pkg::TaskCount); i++) cnt_q[i] <= 2'd0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          gda_pkg::RegTrigThr:  trig_thr_q  <= cfg_data_i[14:0];
          gda_pkg::RegStickThr: stick_thr_q <= cfg_data_i[14:0];
          gda_pkg::RegMargin:   margin_q    <= cfg_data_i[13:0];
          gda_pkg::RegDelay:    delay_q     <= cfg_data_i;
          gda_pkg::RegPeriod:   period_q    <= cfg_data_i;
          gda_pkg::RegDiag:     diag_q      <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.ev_exec) begin
        trig_on_q <= trig_d;
        stick_q   <= stick_d;
        hat_q     <= hat_d;
        if (ev_arm)      cnt_q[t_ev] <= ev_arm_cnt;
        else if (ev_clr) cnt_q[t_ev] <= 2'd0;
      end
      if (cmd_i.sc_start) begin
        idx_q        <= '0;
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.sc_chk) begin
        idx_q <= idx_q + IW'(1);
        if (due_hit) begin
          pend_valid_q <= 1'b1;
          if (cnt_q[idx_q] != 2'd2) cnt_q[idx_q] <= cnt_q[idx_q] + 2'd1;
        end
      end
      if (cmd_i.sc_flush) pend_valid_q <= 1'b0;
      if (push)                           out_valid_q <= 1'b1;
      else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign stat_o.is_tick    = (op_q == gda_pkg::OpTick);
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.idx_last   = (idx_q == gda_pkg::LastTask);
  assign stat_o.pend_valid = pend_valid_q;
  assign stat_o.due_hit    = due_hit;

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_code_o  = out_code_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/gda_checker.sv =====
// Port-level checks for the gamepad direction autorepeat block, with bind.
module gda_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic [2:0] m_axis_tuser_o,
  input logic       m_axis_tlast_o
);

  // one event at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while busy");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o <= 8'd38))
    else $error("key code out of range");

  // keyboard words stand alone with a zero code
  a_kbd_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != gda_pkg::KindPad) |->
      (m_axis_tlast_o && m_axis_tdata_o == 8'd0))
    else $error("bad keyboard word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled output word changed");

endmodule

bind gamepad_direction_autorepeat gda_checker u_gda_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

// ===== sim/gamepad_direction_autorepeat_tb.sv =====
// Self-checking testbench for the gamepad direction and autorepeat block.
module gamepad_direction_autorepeat_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 8000;
  localparam int SettleCycles  = 200;   // idle wait after the last expected key word
  localparam int HoldCycles    = 400;

  typedef struct {
    logic [2:0] kind;
    logic [5:0] code;
    logic       last;
  } key_word_t;

  typedef struct {
    logic [1:0]  op;
    logic [2:0]  axis;
    logic [15:0] value;
    logic [3:0]  hat;
    logic [4:0]  btn;
    logic        pressed;
    logic [31:0] stamp;
    bit          typed;     // first key word given below
    logic [2:0]  kind;
    logic [5:0]  code;
  } pad_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [63:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [7:0]  m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_addr_i = '0;
  logic [15:0] cfg_data_i = '0;

  gamepad_direction_autorepeat uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  logic [14:0] trig_thr, stick_thr;
  logic [13:0] margin;
  logic [15:0] rpt_delay, rpt_period, diag_wait;

  logic        trig_on   [2];
  logic [3:0]  stick_dir [2];
  logic [3:0]  hat_dir;
  logic [31:0] task_due  [gda_pkg::TaskCount];
  logic [5:0]  task_code [gda_pkg::TaskCount];
  logic [1:0]  task_cnt  [gda_pkg::TaskCount];

  key_word_t pending_keys[$];   // words of the event being predicted
  key_word_t key_q[$];          // words still to come out of the block

  int errors = 0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // pattern -> up,right,down,left,ru,rd,ld,lu slot; -1 when no code
  function automatic int direction_slot(input logic [3:0] d);
    case (d)
      4'd1:    return 0;
      4'd2:    return 1;
      4'd4:    return 2;
      4'd8:    return 3;
      4'd3:    return 4;
      4'd6:    return 5;
      4'd12:   return 6;
      4'd9:    return 7;
      default: return -1;
    endcase
  endfunction

  function automatic void push_key(input logic [2:0] k, input logic [5:0] c);
    key_word_t w;
    w.kind = k;
    w.code = c;
    w.last = 1'b0;
    pending_keys.push_back(w);
  endfunction

  function automatic void arm_task(input int t, input logic [31:0] due,
                                   input logic [5:0] c, input logic [1:0] n);
    task_due[t]  = due;
    task_code[t] = c;
    task_cnt[t]  = n;
  endfunction

  function automatic void track_direction(input int t, input logic [5:0] base,
                                          input logic [31:0] now,
                                          input logic [3:0] was, input logic [3:0] is);
    int s;
    s = direction_slot(is);
    if (was == is) return;
    if (is == 4'd0) begin
      // quick flick: a cardinal that never repeated emits once on return
      if (task_cnt[t] == 2'd1 && direction_slot(was) inside {[0:3]})
        push_key(gda_pkg::KindPad, task_code[t]);
      task_cnt[t] = 2'd0;
    end else if (s >= 4) begin
      push_key(gda_pkg::KindPad, base + 6'(s));
      arm_task(t, now + rpt_delay, base + 6'(s), 2'd1);
    end else if (s >= 0) begin
      arm_task(t, now + diag_wait, base + 6'(s), (was != 0) ? 2'd2 : 2'd1);
    end
  endfunction

  function automatic void predict_keys(input pad_event_t e);
    int v, th, mg, st, t;
    logic [3:0] hi, lo, was, is;
    v  = $signed(e.value);
    mg = int'(margin);
    pending_keys.delete();
    case (e.op)
      gda_pkg::OpAxis: begin
        if (e.axis == 3'd4 || e.axis == 3'd5) begin
          st = e.axis - 4;
          th = int'(trig_thr);
          t  = int'(gda_pkg::TrigBase) + st;
          if (!trig_on[st] && v > th + mg) begin
            push_key(gda_pkg::KindPad, gda_pkg::TrigCode + 6'(st));
            trig_on[st] = 1'b1;
            arm_task(t, e.stamp + rpt_delay, gda_pkg::TrigCode + 6'(st), 2'd1);
          end else if (trig_on[st] && v < th - mg) begin
            trig_on[st] = 1'b0;
            task_cnt[t] = 2'd0;
          end
        end else if (e.axis <= 3'd3) begin
          st  = e.axis >> 1;
          th  = int'(stick_thr);
          hi  = e.axis[0] ? 4'd4 : 4'd2;
          lo  = e.axis[0] ? 4'd1 : 4'd8;
          was = stick_dir[st];
          is  = was;
          if (!(was & hi) && v > th + mg) is = was | hi;
          else if ((was & hi) && v < th - mg) is = was & ~hi;
          else if (!(was & lo) && v < -th - mg) is = was | lo;
          else if ((was & lo) && v > -th + mg) is = was & ~lo;
          stick_dir[st] = is;
          track_direction(int'(gda_pkg::StickBase) + st,
                          st ? gda_pkg::Stick1Base : gda_pkg::Stick0Base,
                          e.stamp, was, is);
        end
      end
      gda_pkg::OpHat: begin
        was = hat_dir;
        hat_dir = e.hat;
        track_direction(int'(gda_pkg::HatTask), gda_pkg::HatBase, e.stamp, was, e.hat);
      end
      gda_pkg::OpButton: begin
        if (e.btn < gda_pkg::ButtonCount) begin
          if (!e.pressed) task_cnt[e.btn] = 2'd0;
          else case (e.btn)
            gda_pkg::BtnEsc:   push_key(gda_pkg::KindEsc, 6'd0);
            gda_pkg::BtnEnter: push_key(gda_pkg::KindEnter, 6'd0);
            gda_pkg::BtnUp:    push_key(gda_pkg::KindUp, 6'd0);
            gda_pkg::BtnDown:  push_key(gda_pkg::KindDown, 6'd0);
            gda_pkg::BtnLeft:  push_key(gda_pkg::KindLeft, 6'd0);
            gda_pkg::BtnRight: push_key(gda_pkg::KindRight, 6'd0);
            default: begin
              push_key(gda_pkg::KindPad, 6'(e.btn));
              arm_task(int'(e.btn), e.stamp + rpt_delay, 6'(e.btn), 2'd1);
            end
          endcase
        end
      end
      default: begin
        // scheduler tick: due tasks fire in index order
        for (int i = 0; i < gda_pkg::TaskCount; i++) begin
          if (task_cnt[i] != 0 && task_due[i] <= e.stamp) begin
            push_key(gda_pkg::KindPad, task_code[i]);
            if (task_cnt[i] < 2) task_cnt[i]++;
            task_due[i] = e.stamp + rpt_period;
          end
        end
      end
    endcase
    if (pending_keys.size() > 0) pending_keys[$].last = 1'b1;
    foreach (pending_keys[i]) key_q.push_back(pending_keys[i]);
  endfunction

  // ---------------------------------------------------------------- receiver
  int recv_idle_pct = 0;
  int send_idle_pct = 0;
  int hold_req = 0;        // bumped by the sender to request a long hold-off
  int hold_seen = 0;
  int hold_left = 0;

  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // check every key word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (key_q.size() == 0) begin
        report($sformatf("unexpected key word code=%0d kind=%0d",
                         m_axis_tdata_o, m_axis_tuser_o));
      end else begin
        key_word_t w;
        w = key_q.pop_front();
        if (m_axis_tdata_o !== {2'b00, w.code})
          report($sformatf("key_code %0d, expected %0d", m_axis_tdata_o, w.code));
        if (m_axis_tuser_o !== w.kind)
          report($sformatf("key_kind %0d, expected %0d", m_axis_tuser_o, w.kind));
        if (m_axis_tlast_o !== w.last)
          report($sformatf("tlast %0b, expected %0b", m_axis_tlast_o, w.last));
      end
    end
  end

  // watchdog: cycles without any handshake
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
        || (cfg_valid_i && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gda_pkg::RegTrigThr:  trig_thr   = data[14:0];
      gda_pkg::RegStickThr: stick_thr  = data[14:0];
      gda_pkg::RegMargin:   margin     = data[13:0];
      gda_pkg::RegDelay:    rpt_delay  = data;
      gda_pkg::RegPeriod:   rpt_period = data;
      gda_pkg::RegDiag:     diag_wait  = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_event(input pad_event_t e);
    int gap;
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= e.op;
    s_axis_tdata_i  <= {3'b0, e.stamp, e.pressed, e.btn, e.hat, e.value, e.axis};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_keys(e);
    if (e.typed && (pending_keys.size() == 0 || pending_keys[0].kind !== e.kind
                    || pending_keys[0].code !== e.code))
      report($sformatf("directed op %0d: first key not kind=%0d code=%0d",
                       e.op, e.kind, e.code));
  endtask

  // stop offering and let the block empty out
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (key_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic pad_event_t mk(input logic [1:0] op, input logic [2:0] axis,
                                    input logic [15:0] value, input logic [3:0] hat,
                                    input logic [4:0] btn, input logic pressed,
                                    input logic [31:0] stamp);
    pad_event_t e;
    e.op = op; e.axis = axis; e.value = value; e.hat = hat;
    e.btn = btn; e.pressed = pressed; e.stamp = stamp;
    e.typed = 1'b0; e.kind = gda_pkg::KindPad; e.code = '0;
    return e;
  endfunction

  function automatic pad_event_t typed_row(input pad_event_t e, input logic [2:0] k,
                                           input logic [5:0] c);
    e.typed = 1'b1;
    e.kind  = k;
    e.code  = c;
    return e;
  endfunction

  logic [31:0] clock_ms = 32'd0;

  // axis values clustered on the hysteresis edges of the current setting
  function automatic logic [15:0] edge_value(input bit trig);
    int th, mg;
    th = trig ? int'(trig_thr) : int'(stick_thr);
    mg = int'(margin);
    case ($urandom_range(8))
      0: return 16'(th + mg + 1);
      1: return 16'(th + mg);
      2: return 16'(th - mg - 1);
      3: return 16'(-th - mg - 1);
      4: return 16'(-th + mg + 1);
      5: return 16'd0;
      6: return 16'h7FFF;
      7: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pad_event_t random_event();
    pad_event_t e;
    int pick;
    e = mk(2'($urandom_range(3)), 3'($urandom_range(7)), 16'($urandom), 4'($urandom),
           5'($urandom), 1'($urandom), 32'd0);
    clock_ms += $urandom_range(0, 120);
    e.stamp = ($urandom_range(99) < 4) ? $urandom : clock_ms;
    pick = $urandom_range(99);
    if (pick < 30) begin
      e.op = gda_pkg::OpTick;
    end else if (pick < 60) begin
      e.op = gda_pkg::OpAxis;
      e.axis = ($urandom_range(19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(5));
      e.value = edge_value(e.axis >= 3'd4);
    end else if (pick < 75) begin
      e.op = gda_pkg::OpHat;
      // mostly codable patterns, centre often
      if ($urandom_range(3) != 0) e.hat = ($urandom_range(2) == 0) ? 4'd0 : 4'(1 << $urandom_range(3));
    end else begin
      e.op = gda_pkg::OpButton;
      if ($urandom_range(9) == 0) e.btn = 5'($urandom_range(30, 31));
      else e.btn = 5'($urandom_range(gda_pkg::ButtonCount - 1));
    end
    return e;
  endfunction

  pad_event_t directed[$];

  initial begin
    trig_thr = 15'd16000; stick_thr = 15'd16000; margin = 14'd2000;
    rpt_delay = 16'd400; rpt_period = 16'd200; diag_wait = 16'd250;
    for (int i = 0; i < 2; i++) begin
      trig_on[i] = 1'b0;
      stick_dir[i] = 4'd0;
    end
    hat_dir = 4'd0;
    for (int i = 0; i < gda_pkg::TaskCount; i++) begin
      task_due[i] = '0;
      task_code[i] = '0;
      task_cnt[i] = '0;
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: keyboard buttons, repeat tasks, triggers, flick, diagonal, hat
    directed.push_back(typed_row(mk(gda_pkg::OpButton, 0, 0, 0, gda_pkg::BtnEsc, 1, 0),
                                 gda_pkg::KindEsc, 0));
    directed.push_back(typed_row(mk(gda_pkg::OpButton, 0, 0, 0, gda_pkg::BtnEnter, 1, 0),
                                 gda_pkg::KindEnter, 0));
    directed.push_back(typed_row(mk(gda_pkg::OpButton, 0, 0, 0, gda_pkg::BtnUp, 1, 0),
                                 gda_pkg::KindUp, 0));
    directed.push_back(typed_row(mk(gda_pkg::OpButton, 0, 0, 0, gda_pkg::BtnDown, 1, 0),
                                 gda_pkg::KindDown, 0));
    directed.push_back(typed_row(mk(gda_pkg::OpButton, 0, 0, 0, gda_pkg::BtnLeft, 1, 0),
                                 gda_pkg::KindLeft, 0));
    directed.push_back(typed_row(mk(gda_pkg::OpButton, 0, 0, 0, gda_pkg::BtnRight, 1, 0),
                                 gda_pkg::KindRight, 0));
    directed.push_back(typed_row(mk(gda_pkg::OpButton, 0, 0, 0, 5'd0, 1, 0),
                                 gda_pkg::KindPad, 0));
    directed.push_back(typed_row(mk(gda_pkg::OpButton, 0, 0, 0, 5'd29, 1, 10),
                                 gda_pkg::KindPad, 29));
    directed.push_back(mk(gda_pkg::OpButton, 0, 0, 0, 5'd30, 1, 10));
    directed.push_back(mk(gda_pkg::OpButton, 0, 0, 0, 5'd31, 1, 10));
    directed.push_back(mk(gda_pkg::OpTick, 0, 0, 0, 0, 0, 500));
    directed.push_back(mk(gda_pkg::OpButton, 0, 0, 0, 5'd0, 0, 510));
    directed.push_back(typed_row(mk(gda_pkg::OpAxis, 3'd4, 16'h7FFF, 0, 0, 0, 600),
                                 gda_pkg::KindPad, 29));
    directed.push_back(typed_row(mk(gda_pkg::OpAxis, 3'd5, 16'd18001, 0, 0, 0, 600),
                                 gda_pkg::KindPad, 30));
    directed.push_back(mk(gda_pkg::OpAxis, 3'd4, 16'h8000, 0, 0, 0, 610));
    directed.push_back(mk(gda_pkg::OpAxis, 3'd0, 16'h7FFF, 0, 0, 0, 1000));
    directed.push_back(typed_row(mk(gda_pkg::OpAxis, 3'd0, 16'd0, 0, 0, 0, 1010),
                                 gda_pkg::KindPad, 32));
    directed.push_back(mk(gda_pkg::OpAxis, 3'd1, 16'h8000, 0, 0, 0, 1100));
    directed.push_back(typed_row(mk(gda_pkg::OpAxis, 3'd0, 16'h7FFF, 0, 0, 0, 1110),
                                 gda_pkg::KindPad, 35));
    directed.push_back(mk(gda_pkg::OpAxis, 3'd3, 16'h8000, 0, 0, 0, 1120));
    directed.push_back(mk(gda_pkg::OpAxis, 3'd6, 16'h7FFF, 0, 0, 0, 1130));
    directed.push_back(mk(gda_pkg::OpAxis, 3'd7, 16'h8000, 0, 0, 0, 1130));
    directed.push_back(mk(gda_pkg::OpHat, 0, 0, 4'd5, 0, 0, 1200));
    directed.push_back(mk(gda_pkg::OpHat, 0, 0, 4'd15, 0, 0, 1200));
    directed.push_back(typed_row(mk(gda_pkg::OpHat, 0, 0, 4'd3, 0, 0, 1210),
                                 gda_pkg::KindPad, 35));
    directed.push_back(mk(gda_pkg::OpTick, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    foreach (directed[i]) send_event(directed[i]);
    drain();

    // random phases, each under its own register setting
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(gda_pkg::RegTrigThr, 16'd12000);
          write_reg(gda_pkg::RegStickThr, 16'd12000);
          write_reg(gda_pkg::RegMargin, 16'd1000);
          write_reg(gda_pkg::RegDelay, 16'd100);
          write_reg(gda_pkg::RegPeriod, 16'd50);
          write_reg(gda_pkg::RegDiag, 16'd80);
          send_idle_pct = 32; recv_idle_pct = 75;
        end
        1: begin
          // lowest setting
          write_reg(gda_pkg::RegTrigThr, 16'd0);
          write_reg(gda_pkg::RegStickThr, 16'd0);
          write_reg(gda_pkg::RegMargin, 16'd0);
          write_reg(gda_pkg::RegDelay, 16'd0);
          write_reg(gda_pkg::RegPeriod, 16'd1);
          write_reg(gda_pkg::RegDiag, 16'd0);
          send_idle_pct = 75; recv_idle_pct = 32;
        end
        2: begin
          // all-ones writes: highest setting after field masking
          write_reg(gda_pkg::RegTrigThr, 16'hFFFF);
          write_reg(gda_pkg::RegStickThr, 16'hFFFF);
          write_reg(gda_pkg::RegMargin, 16'hFFFF);
          write_reg(gda_pkg::RegDelay, 16'hFFFF);
          write_reg(gda_pkg::RegPeriod, 16'hFFFF);
          write_reg(gda_pkg::RegDiag, 16'hFFFF);
          send_idle_pct = 0; recv_idle_pct = 0;
        end
        default: begin
          write_reg(gda_pkg::RegTrigThr, 16'($urandom_range(32767)));
          write_reg(gda_pkg::RegStickThr, 16'($urandom_range(20000)));
          write_reg(gda_pkg::RegMargin, 16'($urandom_range(4000)));
          write_reg(gda_pkg::RegDelay, 16'($urandom_range(300)));
          write_reg(gda_pkg::RegPeriod, 16'($urandom_range(1, 150)));
          write_reg(gda_pkg::RegDiag, 16'($urandom_range(200)));
          write_reg(3'd7, 16'($urandom));   // unmapped index, ignored
          send_idle_pct = 0; recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < 85; n++) begin
        if (ph == 2 && n == 10) hold_req++;   // receiver backs off, input stalls
        if (ph == 3 && n == 40) begin
          // sender stops offering and waits until every key word is out
          @(negedge clk_i);
          s_axis_tvalid_i <= 1'b0;
          while (key_q.size() != 0) @(posedge clk_i);
        end
        send_event(random_event());
      end
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/gda_pkg.sv
rtl/gda_ctrl.sv
rtl/gda_dp.sv
rtl/gamepad_direction_autorepeat.sv
rtl/gda_checker.sv
sim/gamepad_direction_autorepeat_tb.sv
